[rtl/core/nptq_pkg.sv]
// Shared constants, types and helpers for the nested priority task queue.
// Used by the RAM-based queue core and its port checker; no dependencies.
`timescale 1ns / 1ps

package nptq_pkg;

  // Queue and nesting stack sizes.
  localparam int Q_DEPTH = 16;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  localparam int N_DEPTH = 8;
  localparam int N_AW    = (N_DEPTH > 1) ? $clog2(N_DEPTH) : 1;
  localparam int N_CW    = $clog2(N_DEPTH + 1);

  // Field widths.
  localparam int ID_W  = 8;
  localparam int LVL_W = 16;

  localparam logic [LVL_W-1:0] IDLE_LEVEL_RESET = 16'd9999;

  // Item function codes.
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_QFULL     = 2'd1;
  localparam logic [1:0] ERR_IDLE_FIN  = 2'd2;
  localparam logic [1:0] ERR_NEST_FULL = 2'd3;

  // One queue entry as stored in the queue RAM.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] level;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Physical queue address of logical position off, counted from the head.
  function automatic logic [Q_AW-1:0] q_phys(input logic [Q_AW-1:0] head,
                                             input logic [Q_CW-1:0] off);
    logic [Q_AW+1:0] s;
    s = (Q_AW+2)'(head) + (Q_AW+2)'(off);
    if (s >= (Q_AW+2)'(Q_DEPTH)) begin
      s = s - (Q_AW+2)'(Q_DEPTH);
    end
    return s[Q_AW-1:0];
  endfunction

endpackage

[rtl/core/nptq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the task queue and the nesting level stack.
`timescale 1ns / 1ps

module nptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and a read whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/nested_priority_irq_task_queue.sv]
// Nested priority task queue: level-sorted circular queue RAM plus a stack RAM of saved levels.
// An add walks the sorted-insert path (S_INS_START, S_INS_WALK, S_INS_PUT), a finish pops the stack
// in S_POP; every item then reads the head in S_HEAD_RD and decides in S_HEAD_CHK.
// One item is in work at a time and the next is taken once its result is registered;
// the sorted-insert walk moves one entry per cycle, and S_HEAD_CHK waits on a result stall.
// Synchronous reset empties the queue and the stack and sets the internal running level to 9999.
`timescale 1ns / 1ps

module nested_priority_irq_task_queue (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel (idle_level)
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nptq_pkg::LVL_W-1:0]   cfg_data,
  // Input item channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [nptq_pkg::ID_W-1:0]    task_id,
  input  logic [nptq_pkg::LVL_W-1:0]   priority_req,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         dispatch_valid,
  output logic [nptq_pkg::ID_W-1:0]    dispatch_id,
  output logic [nptq_pkg::LVL_W-1:0]   dispatch_priority,
  output logic [nptq_pkg::LVL_W-1:0]   running_level,
  output logic [nptq_pkg::Q_CW-1:0]    queue_count,
  output logic [1:0]                   error
);

  localparam int QCW = nptq_pkg::Q_CW;
  localparam int QAW = nptq_pkg::Q_AW;
  localparam int NCW = nptq_pkg::N_CW;
  localparam int NAW = nptq_pkg::N_AW;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_START = 7'b0000010,
    S_INS_WALK  = 7'b0000100,
    S_INS_PUT   = 7'b0001000,
    S_POP       = 7'b0010000,
    S_HEAD_RD   = 7'b0100000,
    S_HEAD_CHK  = 7'b1000000
  } state_t;

  state_t                       state;
  logic [nptq_pkg::ID_W-1:0]    op_id;
  logic [nptq_pkg::LVL_W-1:0]   op_lvl;
  logic [1:0]                   err;
  logic [QAW-1:0]               head;
  logic [QCW-1:0]               count;
  logic [NCW-1:0]               nest;
  logic [nptq_pkg::LVL_W-1:0]   cur_level;
  logic [QAW-1:0]               walk_k;

  // RAM ports
  logic                         q_we;
  logic [QAW-1:0]               q_waddr;
  nptq_pkg::entry_t             q_wdata;
  logic                         q_re;
  logic [QAW-1:0]               q_raddr;
  nptq_pkg::entry_t             q_rdata;
  logic                         s_we;
  logic [NAW-1:0]               s_waddr;
  logic [nptq_pkg::LVL_W-1:0]   s_wdata;
  logic                         s_re;
  logic [NAW-1:0]               s_raddr;
  logic [nptq_pkg::LVL_W-1:0]   s_rdata;

  logic                         in_beat;
  logic                         slot_free;
  logic                         due;
  logic                         nest_full;
  logic                         dispatch_now;
  logic                         out_load;
  nptq_pkg::entry_t             new_entry;
  logic                         walk_shift;

  nptq_ram #(
    .WIDTH (nptq_pkg::ENTRY_W),
    .DEPTH (nptq_pkg::Q_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  nptq_ram #(
    .WIDTH (nptq_pkg::LVL_W),
    .DEPTH (nptq_pkg::N_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Handshake and per-item decisions. Register beats are taken only between items.
  assign in_ready     = (state == S_IDLE);
  assign cfg_ready    = (state == S_IDLE);
  assign in_beat      = in_valid && in_ready;
  assign slot_free    = !out_valid || out_ready;
  assign due          = (count != '0) && (q_rdata.level < cur_level);
  assign nest_full    = (nest == NCW'(nptq_pkg::N_DEPTH));
  assign dispatch_now = due && !nest_full;
  assign out_load     = (state == S_HEAD_CHK) && slot_free;
  assign new_entry    = '{id: op_id, level: op_lvl};
  assign walk_shift   = (q_rdata.level > op_lvl);

  // RAM control: the insert walk writes entry k into slot k + 1 while reading entry k - 1.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = head;
    q_wdata = new_entry;
    q_re    = 1'b0;
    q_raddr = head;
    s_we    = 1'b0;
    s_waddr = nest[NAW-1:0];
    s_wdata = cur_level;
    s_re    = 1'b0;
    s_raddr = '0;
    case (state)
      S_IDLE: begin
        if (in_beat && (func == nptq_pkg::FUNC_FINISH) && (nest != '0)) begin
          s_re    = 1'b1;
          s_raddr = NAW'(nest - NCW'(1));
        end
      end
      S_INS_START: begin
        if (count == '0) begin
          q_we    = 1'b1;
          q_waddr = head;
        end else begin
          q_re    = 1'b1;
          q_raddr = nptq_pkg::q_phys(head, count - QCW'(1));
        end
      end
      S_INS_WALK: begin
        q_we    = 1'b1;
        q_waddr = nptq_pkg::q_phys(head, QCW'(walk_k) + QCW'(1));
        if (walk_shift) begin
          q_wdata = q_rdata;
          if (walk_k != '0) begin
            q_re    = 1'b1;
            q_raddr = nptq_pkg::q_phys(head, QCW'(walk_k) - QCW'(1));
          end
        end
      end
      S_INS_PUT: begin
        q_we    = 1'b1;
        q_waddr = head;
      end
      S_HEAD_RD: begin
        q_re    = 1'b1;
        q_raddr = head;
      end
      S_HEAD_CHK: begin
        if (slot_free && dispatch_now) begin
          s_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, queue and stack bookkeeping, result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      nest       <= '0;
      cur_level  <= nptq_pkg::IDLE_LEVEL_RESET;
      out_valid  <= 1'b0;
      err        <= nptq_pkg::ERR_NONE;
    end else begin
      // Result register: a new beat may replace the one leaving in the same cycle.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Configuration beat; the running level follows while nothing is nested.
      if (cfg_valid && cfg_ready) begin
        if (nest == '0) begin
          cur_level <= cfg_data;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            op_id   <= task_id;
            op_lvl  <= priority_req;
            if (func == nptq_pkg::FUNC_ADD) begin
              if (count >= QCW'(nptq_pkg::Q_DEPTH)) begin
                err   <= nptq_pkg::ERR_QFULL;
                state <= S_HEAD_RD;
              end else begin
                err   <= nptq_pkg::ERR_NONE;
                state <= S_INS_START;
              end
            end else begin
              if (nest == '0) begin
                err   <= nptq_pkg::ERR_IDLE_FIN;
                state <= S_HEAD_RD;
              end else begin
                err   <= nptq_pkg::ERR_NONE;
                nest  <= nest - NCW'(1);
                state <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          cur_level <= s_rdata;
          state     <= S_HEAD_RD;
        end
        S_INS_START: begin
          if (count == '0) begin
            count <= QCW'(1);
            state <= S_HEAD_RD;
          end else begin
            walk_k <= QAW'(count - QCW'(1));
            state  <= S_INS_WALK;
          end
        end
        S_INS_WALK: begin
          if (walk_shift) begin
            if (walk_k == '0) begin
              state <= S_INS_PUT;
            end else begin
              walk_k <= walk_k - QAW'(1);
            end
          end else begin
            count <= count + QCW'(1);
            state <= S_HEAD_RD;
          end
        end
        S_INS_PUT: begin
          count <= count + QCW'(1);
          state <= S_HEAD_RD;
        end
        S_HEAD_RD: begin
          state <= S_HEAD_CHK;
        end
        S_HEAD_CHK: begin
          // Wait here until the result register can take the beat.
          if (slot_free) begin
            dispatch_valid    <= dispatch_now;
            dispatch_id       <= dispatch_now ? q_rdata.id : '0;
            dispatch_priority <= dispatch_now ? q_rdata.level : '0;
            running_level     <= dispatch_now ? q_rdata.level : cur_level;
            queue_count       <= dispatch_now ? (count - QCW'(1)) : count;
            // A full stack is reported only when the item raised no earlier error.
            error             <= (due && nest_full && (err == nptq_pkg::ERR_NONE)) ?
                                 nptq_pkg::ERR_NEST_FULL : err;
            if (dispatch_now) begin
              head      <= nptq_pkg::q_phys(head, QCW'(1));
              count     <= count - QCW'(1);
              nest      <= nest + NCW'(1);
              cur_level <= q_rdata.level;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/nptq_checker.sv]
// Port-level checker for the nested priority task queue, bound to the top level.
// Depends on nptq_pkg for sizes and error codes.
`timescale 1ns / 1ps

module nptq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         dispatch_valid,
  input logic [nptq_pkg::ID_W-1:0]    dispatch_id,
  input logic [nptq_pkg::LVL_W-1:0]   dispatch_priority,
  input logic [nptq_pkg::LVL_W-1:0]   running_level,
  input logic [nptq_pkg::Q_CW-1:0]    queue_count,
  input logic [1:0]                   error
);

  // The pending count never exceeds the queue size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (queue_count <= nptq_pkg::Q_CW'(nptq_pkg::Q_DEPTH)))
    else $error("queue_count above queue depth");

  // A dispatched task becomes the running level.
  a_dispatch_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dispatch_valid) |-> (running_level == dispatch_priority))
    else $error("running level differs from dispatched priority");

  // Without a dispatch the id and priority read as zero.
  a_no_dispatch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dispatch_valid) |-> (dispatch_id == '0 && dispatch_priority == '0))
    else $error("dispatch fields not cleared");

  // A full nesting stack holds the dispatch back.
  a_nest_full_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error == nptq_pkg::ERR_NEST_FULL) |-> !dispatch_valid)
    else $error("dispatch despite full nesting stack");

  // A stalled result beat keeps its running level, queue count and error.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(running_level) &&
                                   $stable(queue_count) && $stable(error)))
    else $error("result beat changed while stalled");

endmodule

bind nested_priority_irq_task_queue nptq_checker u_nptq_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .dispatch_valid    (dispatch_valid),
  .dispatch_id       (dispatch_id),
  .dispatch_priority (dispatch_priority),
  .running_level     (running_level),
  .queue_count       (queue_count),
  .error             (error)
);
